// ===== rtl/frame_border_profile_color_check_macros.svh =====
// Assertion macros used by the frame border profile checker queue module.
`ifndef FRAME_BORDER_PROFILE_COLOR_CHECK_MACROS_SVH
`define FRAME_BORDER_PROFILE_COLOR_CHECK_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define FBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define FBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fbp_pkg.sv =====
// Types, constants and codes shared by the frame border profile checker.
package fbp_pkg;

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 1024;

  localparam int unsigned SizeW    = 11;
  localparam int unsigned CntW     = 10;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned LumW     = 10;
  localparam int unsigned StripW   = 17;
  localparam int unsigned TotalW   = 28;
  localparam int unsigned PixW     = 2 * SizeW;
  localparam int unsigned ProdW    = PixW + LevelW;
  localparam int unsigned DivW     = StripW + 3;
  localparam int unsigned DenW     = SizeW + 2;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = 2;
  localparam int unsigned QCntW    = 3;
  localparam int unsigned NCmd     = 3;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam logic [SizeW-1:0] ResetWidth  = 11'd640;
  localparam logic [SizeW-1:0] ResetHeight = 11'd480;
  localparam logic [SizeW-1:0] MinSize     = 11'd8;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_RED_THR      = 3'd2,
    REG_GREEN_THR    = 3'd3,
    REG_BLUE_THR     = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    KIND_LEFT    = 3'd0,
    KIND_RIGHT   = 3'd1,
    KIND_TOP     = 3'd2,
    KIND_BOTTOM  = 3'd3,
    KIND_VERDICT = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_READ,
    FR_UPDATE
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [LevelW-1:0] red_level;
    logic [LevelW-1:0] green_level;
    logic [LevelW-1:0] blue_level;
  } pixel_t;

  typedef struct packed {
    kind_e             kind;
    logic [CntW-1:0]   position;
    logic [LevelW-1:0] profile_level;
    logic              passed;
    logic              last;
  } result_t;

  typedef struct packed {
    kind_e             kind;
    logic [CntW-1:0]   position;
    logic [StripW-1:0] sum;
    logic              passed;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [SizeW-1:0]  frame_width;
    logic [SizeW-1:0]  frame_height;
    logic [LevelW-1:0] red_threshold;
    logic [LevelW-1:0] green_threshold;
    logic [LevelW-1:0] blue_threshold;
  } cfg_t;

  typedef struct packed {
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
  } dims_t;

endpackage

// ===== rtl/fbp_front.sv =====
// Front part: accepts pixels, updates strip and frame sums, emits commands.
module fbp_front #(
  parameter int unsigned MaxWidth  = fbp_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = fbp_pkg::DefMaxHeight
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  fbp_pkg::pixel_t             pixel_i,
  input  fbp_pkg::cfg_t               cfg_i,
  input  logic [fbp_pkg::QCntW-1:0]   q_cnt_i,
  output logic [1:0]                  q_push_n_o,
  output fbp_pkg::cmd_t               q_cmd_o [fbp_pkg::NCmd],
  output fbp_pkg::dims_t              dims_o
);
  import fbp_pkg::*;

  localparam int unsigned AW = $clog2(MaxWidth);

  front_state_e       state_q, state_d;
  pixel_t             pix_q;
  logic [CntW-1:0]    col_q, row_q;
  logic [StripW-1:0]  left_q, right_q, rd_q;
  logic [TotalW-1:0]  tot_r_q, tot_g_q, tot_b_q;
  logic [PixW-1:0]    pixels_q;
  logic [ProdW-1:0]   lim_r_q, lim_g_q, lim_b_q;
  logic [StripW-1:0]  col_mem [MaxWidth];

  logic [SizeW-1:0]   w, h, w8, h8, w7, h7, colx, rowx;
  logic               acc, end_row, end_frame, in_mem;
  logic [LumW-1:0]    lum;
  logic [StripW-1:0]  left_sum, right_sum, col_sum;
  logic               left_hit, left_out, top, bot, top_out, bot_out, col_wr, pass;
  logic [TotalW-1:0]  tr, tg, tb;
  logic [AW-1:0]      idx;
  cmd_t               cmds [NCmd];
  logic [1:0]         n;

  always_comb begin
    if (cfg_i.frame_width < MinSize) begin
      w = MinSize;
    end else if (32'(cfg_i.frame_width) > MaxWidth) begin
      w = SizeW'(MaxWidth);
    end else begin
      w = cfg_i.frame_width;
    end
    if (cfg_i.frame_height < MinSize) begin
      h = MinSize;
    end else if (32'(cfg_i.frame_height) > MaxHeight) begin
      h = SizeW'(MaxHeight);
    end else begin
      h = cfg_i.frame_height;
    end
  end

  assign dims_o = '{width: w, height: h};

  // Threshold limits are registered from the thresholds and the registered pixel count.
  always_ff @(posedge clk_i) begin
    pixels_q <= PixW'(w) * PixW'(h);
    lim_r_q  <= ProdW'(cfg_i.red_threshold) * ProdW'(pixels_q);
    lim_g_q  <= ProdW'(cfg_i.green_threshold) * ProdW'(pixels_q);
    lim_b_q  <= ProdW'(cfg_i.blue_threshold) * ProdW'(pixels_q);
  end

  assign full = (state_q != FR_IDLE) || (q_cnt_i > QCntW'(1));
  assign acc  = push && !full;
  assign idx  = AW'(col_q);
  assign in_mem = 32'(col_q) < MaxWidth;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q  <= col_mem[idx];
      pix_q <= pixel_i;
    end
    if (col_wr) begin
      col_mem[idx] <= col_sum;
    end
  end

  always_comb begin
    lum  = LumW'(pix_q.red_level) + LumW'(pix_q.green_level) + LumW'(pix_q.blue_level);
    w8   = w >> 3;
    h8   = h >> 3;
    w7   = SizeW'(((14'(w) << 3) - 14'(w)) >> 3);
    h7   = SizeW'(((14'(h) << 3) - 14'(h)) >> 3);
    colx = SizeW'(col_q);
    rowx = SizeW'(row_q);
    end_row   = (colx + SizeW'(1)) >= w;
    end_frame = end_row && ((rowx + SizeW'(1)) >= h);

    left_hit  = colx < w8;
    left_sum  = left_q + StripW'(lum);
    left_out  = left_hit && (colx == w8 - SizeW'(1));
    right_sum = (colx >= w7) ? right_q + StripW'(lum) : right_q;

    top     = rowx < h8;
    bot     = !top && (rowx >= h7);
    top_out = in_mem && top && (rowx == h8 - SizeW'(1));
    bot_out = in_mem && bot && ((rowx + SizeW'(1)) >= h);
    if ((top && row_q == '0) || (bot && rowx == h7)) begin
      col_sum = StripW'(lum);
    end else begin
      col_sum = rd_q + StripW'(lum);
    end
    col_wr = (state_q == FR_UPDATE) && in_mem && (top || bot);

    tr = tot_r_q + TotalW'(pix_q.red_level);
    tg = tot_g_q + TotalW'(pix_q.green_level);
    tb = tot_b_q + TotalW'(pix_q.blue_level);
    pass = (ProdW'(tr) > lim_r_q) && (ProdW'(tg) > lim_g_q) && (ProdW'(tb) > lim_b_q);

    for (int k = 0; k < NCmd; k++) begin
      cmds[k] = '{kind: KIND_VERDICT, position: '0, sum: '0, passed: 1'b0, last: 1'b0};
    end
    n = '0;
    if (left_out) begin
      cmds[n] = '{kind: KIND_LEFT, position: row_q, sum: left_sum, passed: 1'b0,
                  last: 1'b0};
      n = n + 2'd1;
    end
    if (end_row) begin
      cmds[n] = '{kind: KIND_RIGHT, position: row_q, sum: right_sum, passed: 1'b0,
                  last: 1'b0};
      n = n + 2'd1;
    end
    if (top_out || bot_out) begin
      cmds[n] = '{kind: top_out ? KIND_TOP : KIND_BOTTOM, position: col_q, sum: col_sum,
                  passed: 1'b0, last: 1'b0};
      n = n + 2'd1;
    end
    if (end_frame) begin
      cmds[n] = '{kind: KIND_VERDICT, position: '0, sum: '0, passed: pass, last: 1'b0};
      n = n + 2'd1;
    end
    if (n != '0) begin
      cmds[n - 2'd1].last = 1'b1;
    end
  end

  assign q_cmd_o    = cmds;
  assign q_push_n_o = (state_q == FR_UPDATE) ? n : 2'd0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_IDLE:   if (acc) state_d = FR_READ;
      FR_READ:   state_d = FR_UPDATE;
      FR_UPDATE: state_d = FR_IDLE;
      default:   state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      left_q  <= '0;
      right_q <= '0;
      tot_r_q <= '0;
      tot_g_q <= '0;
      tot_b_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FR_UPDATE) begin
        tot_r_q <= end_frame ? '0 : tr;
        tot_g_q <= end_frame ? '0 : tg;
        tot_b_q <= end_frame ? '0 : tb;
        if (left_out || end_row) begin
          left_q <= '0;
        end else if (left_hit) begin
          left_q <= left_sum;
        end
        right_q <= end_row ? '0 : right_sum;
        if (end_row) begin
          col_q <= '0;
          row_q <= end_frame ? '0 : row_q + CntW'(1);
        end else begin
          col_q <= col_q + CntW'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/fbp_queue.sv =====
// Command queue between the front and back parts; takes up to three per cycle.
`include "frame_border_profile_color_check_macros.svh"
module fbp_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_n_i,
  input  fbp_pkg::cmd_t              cmd_i [fbp_pkg::NCmd],
  input  logic                       pop_i,
  output fbp_pkg::cmd_t              cmd_o,
  output logic [fbp_pkg::QCntW-1:0]  cnt_o
);
  import fbp_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QCntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NCmd; k++) begin
      if (2'(k) < push_n_i) begin
        mem_q[wp_q + QPtrW'(k)] <= cmd_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + QPtrW'(push_n_i);
      rp_q  <= rp_q + QPtrW'(pop_i);
      cnt_q <= cnt_q + QCntW'(push_n_i) - QCntW'(pop_i);
    end
  end

  assign cmd_o = mem_q[rp_q];
  assign cnt_o = cnt_q;

  `FBP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= QCntW'(QDepth), "queue count above depth")
  `FBP_ASSERT_NOW(a_no_overflow, push_n_i != 2'd0,
                  (cnt_q + QCntW'(push_n_i)) <= QCntW'(QDepth), "queue overflow")
  `FBP_ASSERT_NOW(a_no_underflow, pop_i, cnt_q != '0, "pop from empty queue")

endmodule

// ===== rtl/fbp_back.sv =====
// Back part: turns commands into results through a shared bit-serial divider.
module fbp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fbp_pkg::QCntW-1:0]  q_cnt_i,
  input  fbp_pkg::cmd_t              q_cmd_i,
  output logic                       q_pop_o,
  input  fbp_pkg::dims_t             dims_i,
  output logic                       empty,
  input  logic                       pop,
  output fbp_pkg::result_t           result_o
);
  import fbp_pkg::*;

  back_state_e       state_q, state_d;
  cmd_t              cmd_q;
  logic [DivW-1:0]   num_q;
  logic [DenW-1:0]   den_q;
  logic [LevelW-1:0] quo_q;
  logic [2:0]        bit_q;
  result_t           out_q;
  logic              out_valid_q;

  logic [SizeW-1:0]  dim;
  logic [DenW-1:0]   den;
  logic [DivW-1:0]   num;
  logic              sat, fits, load;
  logic [DivW:0]     trial;

  always_comb begin
    dim   = (q_cmd_i.kind == KIND_LEFT || q_cmd_i.kind == KIND_RIGHT) ?
            dims_i.width : dims_i.height;
    den   = (DenW'(dim) << 1) + DenW'(dim);
    num   = {q_cmd_i.sum, 3'b000};
    sat   = {1'b0, num} >= ((DivW+1)'(den) << 8);
    trial = (DivW+1)'(den_q) << bit_q;
    fits  = {1'b0, num_q} >= trial;
    load  = (state_q == BK_DONE) && (!out_valid_q || pop);
  end

  assign q_pop_o = (state_q == BK_IDLE) && (q_cnt_i != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_pop_o) begin
          state_d = (q_cmd_i.kind == KIND_VERDICT || sat) ? BK_DONE : BK_DIV;
        end
      end
      BK_DIV:  if (bit_q == 3'd0) state_d = BK_DONE;
      BK_DONE: if (load) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
      num_q <= num;
      den_q <= den;
      bit_q <= 3'd7;
      quo_q <= (sat && q_cmd_i.kind != KIND_VERDICT) ? '1 : '0;
    end else if (state_q == BK_DIV) begin
      // Restoring step: take one quotient bit per cycle, high bit first.
      if (fits) begin
        num_q        <= num_q - DivW'(trial);
        quo_q[bit_q] <= 1'b1;
      end
      bit_q <= bit_q - 3'd1;
    end
    if (load) begin
      out_q <= '{kind: cmd_q.kind, position: cmd_q.position, profile_level: quo_q,
                 passed: cmd_q.passed, last: cmd_q.last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty    = !out_valid_q;
  assign result_o = out_q;

endmodule

// ===== rtl/frame_border_profile_color_check.sv =====
// An accepted pixel goes through FR_READ and FR_UPDATE, which push its commands into the
// queue; a verdict or a saturated mean then goes straight to BK_DONE in the back part, and
// other means run through the divider first. A verdict follows its row and column results.
// A new pixel is taken only in FR_IDLE, after the column-sum memory read and update of the
// last one, and while the command queue has room. Each unsaturated mean holds the shared
// divider (one quotient bit per cycle); the command queue absorbs the bursts at strip ends.
// Reset clears counters, strip and frame sums and queues; column sums need no clearing.
module frame_border_profile_color_check #(
  parameter int unsigned MaxWidth  = fbp_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = fbp_pkg::DefMaxHeight
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  fbp_pkg::pixel_t             pixel_i,
  output logic                        empty,
  input  logic                        pop,
  output fbp_pkg::result_t            result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fbp_pkg::AddrW-1:0]   paddr,
  input  logic [fbp_pkg::DataW-1:0]   pwdata,
  output logic [fbp_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import fbp_pkg::*;

  cfg_t              cfg_q;
  reg_idx_e          ridx;
  logic              wr;
  logic [QCntW-1:0]  q_cnt;
  logic [1:0]        q_push_n;
  cmd_t              q_cmds [NCmd];
  cmd_t              q_head;
  logic              q_pop;
  dims_t             dims;

  assign pready = 1'b1;
  assign ridx   = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{frame_width: ResetWidth, frame_height: ResetHeight,
                 red_threshold: '0, green_threshold: '0, blue_threshold: '0};
    end else if (wr) begin
      unique case (ridx)
        REG_FRAME_WIDTH:  cfg_q.frame_width     <= pwdata[SizeW-1:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height    <= pwdata[SizeW-1:0];
        REG_RED_THR:      cfg_q.red_threshold   <= pwdata[LevelW-1:0];
        REG_GREEN_THR:    cfg_q.green_threshold <= pwdata[LevelW-1:0];
        REG_BLUE_THR:     cfg_q.blue_threshold  <= pwdata[LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_FRAME_WIDTH:  prdata = DataW'(cfg_q.frame_width);
      REG_FRAME_HEIGHT: prdata = DataW'(cfg_q.frame_height);
      REG_RED_THR:      prdata = DataW'(cfg_q.red_threshold);
      REG_GREEN_THR:    prdata = DataW'(cfg_q.green_threshold);
      REG_BLUE_THR:     prdata = DataW'(cfg_q.blue_threshold);
      default:          prdata = '0;
    endcase
  end

  fbp_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .pixel_i    (pixel_i),
    .cfg_i      (cfg_q),
    .q_cnt_i    (q_cnt),
    .q_push_n_o (q_push_n),
    .q_cmd_o    (q_cmds),
    .dims_o     (dims)
  );

  fbp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (q_push_n),
    .cmd_i    (q_cmds),
    .pop_i    (q_pop),
    .cmd_o    (q_head),
    .cnt_o    (q_cnt)
  );

  fbp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_cnt_i  (q_cnt),
    .q_cmd_i  (q_head),
    .q_pop_o  (q_pop),
    .dims_i   (dims),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

endmodule

// ===== test/tb_frame_border_profile_color_check.sv =====
// Testbench for the frame border profile checker: directed pixels, random frames, checks.
module tb_frame_border_profile_color_check;
  timeunit 1ns;
  timeprecision 1ps;
  import fbp_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned DrainWait  = 60;
  localparam int unsigned RandPixels = 200;

  typedef struct {
    pixel_t  px;
    bit      typed;
    result_t first;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  pixel_t pixel_i = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  // Predictor copy of the registers and the block state.
  logic [SizeW-1:0] cur_width, cur_height;
  logic [LevelW-1:0] red_thr, green_thr, blue_thr;
  logic [StripW-1:0] col_sums [DefMaxWidth];
  logic [StripW-1:0] left_sum, right_sum;
  logic [TotalW-1:0] red_sum, green_sum, blue_sum;
  logic [CntW-1:0] col_cnt, row_cnt;

  result_t profile_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned accepted = 0;
  bit calm = 1'b0;

  frame_border_profile_color_check i_dut (
    .clk_i, .rst_ni, .push, .full, .pixel_i, .empty, .pop, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_frame_border_profile_color_check: errors");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(logic [SizeW-1:0] v, int unsigned hi);
    if (v < 8) return 8;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [LevelW-1:0] mean_of(logic [StripW-1:0] s, int unsigned d);
    longint unsigned m;
    m = (64'(s) * 8) / (64'(d) * 3);
    return (m > 255) ? 8'd255 : m[LevelW-1:0];
  endfunction

  function automatic result_t mk(kind_e k, int unsigned pos, logic [LevelW-1:0] lvl,
                                 bit pass);
    result_t r;
    r.kind = k;
    r.position = pos[CntW-1:0];
    r.profile_level = lvl;
    r.passed = pass;
    r.last = 1'b0;
    return r;
  endfunction

  // Work out the results of one pixel and advance the predictor state.
  function automatic void predict_pixel(pixel_t px, output result_t res[$]);
    int unsigned lum, w, h, col, row;
    bit end_row, end_frame, pass;
    longint unsigned pixels;
    logic [StripW-1:0] s;
    res = {};
    lum = px.red_level + px.green_level + px.blue_level;
    w = clamp_dim(cur_width, DefMaxWidth);
    h = clamp_dim(cur_height, DefMaxHeight);
    col = col_cnt;
    row = row_cnt;
    end_row = (col + 1 >= w);
    end_frame = end_row && (row + 1 >= h);
    red_sum += px.red_level;
    green_sum += px.green_level;
    blue_sum += px.blue_level;
    if (col < w / 8) begin
      left_sum += lum;
      if (col == w / 8 - 1) begin
        res.push_back(mk(KIND_LEFT, row, mean_of(left_sum, w), 1'b0));
        left_sum = '0;
      end
    end
    if (col >= (7 * w) / 8) right_sum += lum;
    if (end_row) begin
      res.push_back(mk(KIND_RIGHT, row, mean_of(right_sum, w), 1'b0));
      right_sum = '0;
      left_sum = '0;
    end
    if (row < h / 8) begin
      s = (row == 0) ? StripW'(lum) : col_sums[col] + StripW'(lum);
      col_sums[col] = s;
      if (row == h / 8 - 1) res.push_back(mk(KIND_TOP, col, mean_of(s, h), 1'b0));
    end else if (row >= (7 * h) / 8) begin
      s = (row == (7 * h) / 8) ? StripW'(lum) : col_sums[col] + StripW'(lum);
      col_sums[col] = s;
      if (row + 1 >= h) res.push_back(mk(KIND_BOTTOM, col, mean_of(s, h), 1'b0));
    end
    if (end_frame) begin
      pixels = longint'(w) * h;
      pass = (red_sum > red_thr * pixels) && (green_sum > green_thr * pixels) &&
             (blue_sum > blue_thr * pixels);
      res.push_back(mk(KIND_VERDICT, 0, '0, pass));
      red_sum = '0;
      green_sum = '0;
      blue_sum = '0;
    end
    if (end_row) begin
      col_cnt = '0;
      row_cnt = end_frame ? '0 : CntW'(row + 1);
    end else begin
      col_cnt = CntW'(col + 1);
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = pixel_t'(24'($urandom));
    case ($urandom_range(9))
      0: p = '0;
      1: p = '1;
      2: p.red_level = 8'hff;
      3: p.blue_level = 8'h00;
      default: ;
    endcase
    return p;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = AddrW'({idx, 2'b00});
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  cur_width = val[SizeW-1:0];
      REG_FRAME_HEIGHT: cur_height = val[SizeW-1:0];
      REG_RED_THR:      red_thr = val[LevelW-1:0];
      REG_GREEN_THR:    green_thr = val[LevelW-1:0];
      default:          blue_thr = val[LevelW-1:0];
    endcase
  endtask

  // Push one pixel, returning the predicted results.
  task automatic send_pixel(pixel_t px, output result_t res[$]);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 23) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    pixel_i = px;
    do @(posedge clk_i); while (full);
    accepted++;
    predict_pixel(px, res);
    foreach (res[i]) profile_q.push_back(res[i]);
  endtask

  task automatic finish_frame();
    result_t res[$];
    while (col_cnt != 0 || row_cnt != 0) send_pixel(rand_pixel(), res);
  endtask

  // Send one whole frame from its first pixel.
  task automatic finish_frame_start();
    result_t res[$];
    send_pixel(rand_pixel(), res);
    finish_frame();
  endtask

  // Hold the sender until every result is out and the block is idle.
  task automatic drain();
    @(negedge clk_i);
    push = 1'b0;
    while (profile_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned rt,
                           int unsigned gt, int unsigned bt);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_RED_THR, rt);
    write_reg(REG_GREEN_THR, gt);
    write_reg(REG_BLUE_THR, bt);
  endtask

  always @(negedge clk_i) begin
    pop = calm || ($urandom_range(99) >= 23);
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && pop && !empty) begin
      if (profile_q.size() == 0) begin
        $error("result with nothing expected: kind %0d", result_o.kind);
        errors++;
      end else begin
        exp_r = profile_q.pop_front();
        if (result_o.kind !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, result_o.kind);
          errors++;
        end
        if (result_o.position !== exp_r.position) begin
          $error("position: expected %0d, got %0d", exp_r.position, result_o.position);
          errors++;
        end
        if (result_o.profile_level !== exp_r.profile_level) begin
          $error("profile_level: expected %0d, got %0d", exp_r.profile_level,
                 result_o.profile_level);
          errors++;
        end
        if (result_o.passed !== exp_r.passed) begin
          $error("passed: expected %0d, got %0d", exp_r.passed, result_o.passed);
          errors++;
        end
        if (result_o.last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, result_o.last);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t dir_rows[12];
    result_t res[$];
    int unsigned start;
    cur_width = 11'd640;
    cur_height = 11'd480;
    red_thr = '0;
    green_thr = '0;
    blue_thr = '0;
    left_sum = '0;
    right_sum = '0;
    red_sum = '0;
    green_sum = '0;
    blue_sum = '0;
    col_cnt = '0;
    row_cnt = '0;
    // Rows 0 and 1 of an 8x8 frame: every column of row 0 closes its one-row top strip.
    dir_rows[0] = '{'{8'hff, 8'hff, 8'hff}, 1'b1, mk(KIND_LEFT, 0, 8'd255, 1'b0)};
    dir_rows[1] = '{'{8'h00, 8'h00, 8'h00}, 1'b1, mk(KIND_TOP, 1, 8'd0, 1'b0)};
    dir_rows[2] = '{'{8'hff, 8'h00, 8'h00}, 1'b0, mk(KIND_TOP, 0, 0, 1'b0)};
    dir_rows[3] = '{'{8'h00, 8'hff, 8'h00}, 1'b0, mk(KIND_TOP, 0, 0, 1'b0)};
    dir_rows[4] = '{'{8'h00, 8'h00, 8'hff}, 1'b0, mk(KIND_TOP, 0, 0, 1'b0)};
    dir_rows[5] = '{'{8'h55, 8'haa, 8'h01}, 1'b0, mk(KIND_TOP, 0, 0, 1'b0)};
    dir_rows[6] = '{'{8'haa, 8'h55, 8'h80}, 1'b0, mk(KIND_TOP, 0, 0, 1'b0)};
    dir_rows[7] = '{'{8'hff, 8'h00, 8'h00}, 1'b1, mk(KIND_RIGHT, 0, 8'd85, 1'b0)};
    dir_rows[8] = '{'{8'hff, 8'hff, 8'hff}, 1'b0, mk(KIND_TOP, 0, 0, 1'b0)};
    dir_rows[9] = '{'{8'h01, 8'h02, 8'h04}, 1'b0, mk(KIND_TOP, 0, 0, 1'b0)};
    dir_rows[10] = '{'{8'h7f, 8'h80, 8'hfe}, 1'b0, mk(KIND_TOP, 0, 0, 1'b0)};
    dir_rows[11] = '{'{8'h00, 8'h00, 8'h00}, 1'b0, mk(KIND_TOP, 0, 0, 1'b0)};
    // The top result is the only one of that pixel.
    dir_rows[1].first.last = 1'b1;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Sizes below the minimum clamp to 8.
    set_frame(0, 3, 0, 0, 0);
    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].px, res);
      if (dir_rows[i].typed && (res.size() == 0 || res[0] != dir_rows[i].first)) begin
        $error("directed row %0d: first result differs from the typed one", i);
        errors++;
      end
    end
    finish_frame();
    drain();

    // Thresholds at the top cannot pass.
    set_frame(9, 8, 255, 255, 255);
    finish_frame_start();
    drain();

    start = accepted;
    while (accepted - start < RandPixels) begin
      set_frame($urandom_range(6, 13), $urandom_range(6, 13), $urandom_range(0, 160),
                $urandom_range(0, 160), $urandom_range(0, 160));
      calm = (accepted - start < 100);
      finish_frame_start();
      drain();
    end
    calm = 1'b0;
    drain();

    if (errors == 0) begin
      $display("tb_frame_border_profile_color_check: clean");
    end else begin
      $display("tb_frame_border_profile_color_check: errors");
    end
    $finish;
  end

endmodule
